@@ rtl/stream_pattern_remover_macros.svh @@
// Assertion macros for the top-level RTL of the pattern remover.
// Define ASSERT_OFF to compile every check away.
`ifndef STREAM_PATTERN_REMOVER_MACROS_SVH
`define STREAM_PATTERN_REMOVER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on clk, suspended while rst_n is low.
`define SPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on clk at every edge, reset included.
`define SPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SPR_ASSERT(label, prop, msg)
`define SPR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/spr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    // Fixed field widths of the streams and registers.
    localparam int DATA_W      = 32;
    localparam int LEN_W       = 3;
    localparam int NUM_WORDS   = 6;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 3;

    // Defaults for the top-level parameters.
    localparam int MAX_PATTERN_DEF = 6;
    localparam int WORD_BITS_DEF   = 32;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_5 = 3'd6;

    // One data request.
    typedef struct packed {
        logic signed [DATA_W-1:0] data_word;
        logic                     final_in;
    } data_item_t;

    // One result request.
    typedef struct packed {
        logic signed [DATA_W-1:0] kept_word;
        logic                     final_out;
        logic                     marker_only;
    } kept_item_t;

    // Register contents as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]                   pattern_len;
        logic [NUM_WORDS-1:0][DATA_W-1:0]   pattern_word;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/spr_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spr_regs
    import spr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [LEN_W-1:0]                 pattern_len_reg;
    logic [NUM_WORDS-1:0][DATA_W-1:0] pattern_word_reg;
    logic [REG_IDX_W-1:0]             reg_idx;
    logic [REG_IDX_W-1:0]             word_idx;
    logic                             wr_en;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[PADDR_W-1:2];
    assign word_idx = reg_idx - REG_PATTERN_WORD_0;
    assign wr_en    = psel && penable && pwrite && pready;

    // Register writes during the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg  <= LEN_W'(1);
            pattern_word_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx) inside
                REG_PATTERN_LEN:
                begin
                    pattern_len_reg <= pwdata[LEN_W-1:0];
                end
                [REG_PATTERN_WORD_0:REG_PATTERN_WORD_5]:
                begin
                    pattern_word_reg[word_idx] <= pwdata[DATA_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read-back mux; unused addresses read as zero.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_PATTERN_LEN:
            begin
                prdata = PDATA_W'(pattern_len_reg);
            end
            [REG_PATTERN_WORD_0:REG_PATTERN_WORD_5]:
            begin
                prdata = PDATA_W'(pattern_word_reg[word_idx]);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.pattern_len  = pattern_len_reg;
    assign cfg.pattern_word = pattern_word_reg;

endmodule

`default_nettype wire

@@ rtl/spr_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spr_out_buf
    import spr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire kept_item_t push_item,
    output logic            full,
    output logic            kept_valid,
    output kept_item_t      kept_item,
    input  wire logic       kept_stall
);

    logic       out_valid_reg;
    kept_item_t out_item_reg;
    logic       skid_valid_reg;
    kept_item_t skid_item_reg;
    logic       out_free;

    // The output slot can be loaded when it is empty or being taken now.
    assign out_free   = !out_valid_reg || !kept_stall;
    assign full       = skid_valid_reg;
    assign kept_valid = out_valid_reg;
    assign kept_item  = out_item_reg;

    // Valid flags of the output register and its skid slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (push_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves; the skid slot drains before new requests.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : push_item;
        end
        else if (push_valid)
        begin
            skid_item_reg <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/stream_pattern_remover.sv @@
// Pattern remover for a stream of signed words.
// Data requests enter on data_valid / data_stall / data_item; a request is
// taken at a rising edge with data_valid high and data_stall low. Results
// leave on kept_valid / kept_stall / kept_item in the same way. Each data
// request is resolved in the cycle it is taken: a kept word goes into the
// output register, or into its skid slot while the output stalls, so
// requests may arrive back to back while data_stall stays low. A request
// with final_in set starts a flush that sends the remaining window from
// its store, one result per cycle while the skid slot is empty, with
// final_out on the last; with nothing left, one marker result goes out.
// data_stall is held high during the flush. A two-entry output register
// with skid slot keeps the input running while one result waits; when it
// fills, data_stall goes high. Reset empties the window and the output
// register and loads the register reset values; the pattern length in
// force is sampled at each step that starts on an empty window. The APB
// port writes registers at byte address four times their index, with no
// wait states.
`timescale 1ns / 1ps
`default_nettype none
`include "stream_pattern_remover_macros.svh"

module stream_pattern_remover
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               data_valid,
    output logic                    data_stall,
    input  wire data_item_t         data_item,
    output logic                    kept_valid,
    input  wire logic               kept_stall,
    output kept_item_t              kept_item
);

    localparam int STORE_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
    localparam int FILL_W     = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    cfg_t                                    cfg;
    logic [MAX_PATTERN-1:0][STORE_BITS-1:0]  win_reg;
    logic [MAX_PATTERN-1:0][STORE_BITS-1:0]  win_push;
    logic [MAX_PATTERN-1:0][STORE_BITS-1:0]  win_shift;
    logic [FILL_W-1:0]                       fill_reg;
    logic [FILL_W-1:0]                       active_len_reg;
    logic                                    flush_reg;
    logic [FILL_W-1:0]                       flush_cnt_reg;
    logic [IDX_W-1:0]                        flush_idx_reg;

    logic [LEN_W-1:0]                        len_clamped;
    logic [FILL_W-1:0]                       eff_len;
    logic [FILL_W-1:0]                       fill_push;
    logic [STORE_BITS-1:0]                   new_word;
    logic                                    win_full;
    logic                                    mismatch;
    logic                                    hit;
    logic                                    accept;
    logic                                    buf_full;
    logic                                    flush_last;
    logic                                    flush_done;
    logic                                    push_valid;
    kept_item_t                              push_item;

    // Register file.
    spr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign data_stall = flush_reg || buf_full;
    assign accept     = data_valid && !data_stall;
    assign new_word   = data_item.data_word[STORE_BITS-1:0];

    // Pattern length in force: sampled from the register on an empty window.
    always_comb
    begin
        if (cfg.pattern_len == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (cfg.pattern_len > LEN_W'(MAX_PATTERN))
        begin
            len_clamped = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_clamped = cfg.pattern_len;
        end
        eff_len = (fill_reg == '0) ? FILL_W'(len_clamped) : active_len_reg;
    end

    // Window with the new word appended, its compare, and its shifted form.
    always_comb
    begin
        fill_push = fill_reg + FILL_W'(1);
        win_full  = fill_push >= eff_len;
        mismatch  = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_push[i] = (FILL_W'(i) == fill_reg) ? new_word : win_reg[i];
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((FILL_W'(i) < eff_len)
                && (win_push[i] != cfg.pattern_word[i][STORE_BITS-1:0]))
            begin
                mismatch = 1'b1;
            end
        end
        hit = win_full && !mismatch;
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            win_shift[i] = win_push[i + 1];
        end
        win_shift[MAX_PATTERN-1] = win_push[MAX_PATTERN-1];
    end

    // Flush progress.
    assign flush_last = (FILL_W'(flush_idx_reg) + FILL_W'(1)) == flush_cnt_reg;
    assign flush_done = (flush_cnt_reg == '0) || flush_last;

    // Result selection: a kept word from the current request or a flush item.
    always_comb
    begin
        push_valid            = 1'b0;
        push_item.kept_word   = DATA_W'(win_push[0]);
        push_item.final_out   = 1'b0;
        push_item.marker_only = 1'b0;
        if (flush_reg)
        begin
            push_valid = !buf_full;
            if (flush_cnt_reg == '0)
            begin
                push_item.kept_word   = '0;
                push_item.final_out   = 1'b1;
                push_item.marker_only = 1'b1;
            end
            else
            begin
                push_item.kept_word = DATA_W'(win_reg[flush_idx_reg]);
                push_item.final_out = flush_last;
            end
        end
        else
        begin
            push_valid = accept && !data_item.final_in && win_full && !hit;
        end
    end

    // Window control and flush sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            active_len_reg <= FILL_W'(1);
            flush_reg      <= 1'b0;
            flush_cnt_reg  <= '0;
            flush_idx_reg  <= '0;
        end
        else if (accept)
        begin
            active_len_reg <= eff_len;
            if (data_item.final_in)
            begin
                fill_reg      <= '0;
                flush_reg     <= 1'b1;
                flush_cnt_reg <= hit ? '0 : fill_push;
                flush_idx_reg <= '0;
            end
            else if (hit)
            begin
                fill_reg <= '0;
            end
            else if (win_full)
            begin
                fill_reg <= fill_push - FILL_W'(1);
            end
            else
            begin
                fill_reg <= fill_push;
            end
        end
        else if (flush_reg && push_valid)
        begin
            if (flush_done)
            begin
                flush_reg <= 1'b0;
            end
            else
            begin
                flush_idx_reg <= flush_idx_reg + IDX_W'(1);
            end
        end
    end

    // Window store; shifted after an emit, else kept as appended.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (win_full && !hit && !data_item.final_in)
            begin
                win_reg <= win_shift;
            end
            else
            begin
                win_reg <= win_push;
            end
        end
    end

    // Output register with skid slot.
    spr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (buf_full),
        .kept_valid (kept_valid),
        .kept_item  (kept_item),
        .kept_stall (kept_stall)
    );

    // Between steps the window never holds a whole pattern.
    `SPR_ASSERT(a_fill_below_len, fill_reg < active_len_reg, "window holds a full pattern")

    // The last flush result ends the flush.
    `SPR_ASSERT(a_flush_ends, (flush_reg && push_valid && push_item.final_out) |=> !flush_reg,
        "flush did not end after its last result")

    // No data request is taken right after a final request starts a flush.
    `SPR_ASSERT(a_no_accept_in_flush, $past(accept && data_item.final_in) |-> data_stall,
        "input taken right after a final request")

endmodule

`default_nettype wire

@@ sim/spr_checker.sv @@
`timescale 1ns / 1ps

// Watches the register port and both request channels of the pattern
// remover. It keeps its own copy of the window and the pattern registers,
// predicts the kept words for every data request taken, and compares each
// result request with the oldest prediction.
module spr_checker
    import spr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               pready,
    input  wire logic               data_valid,
    input  wire logic               data_stall,
    input  data_item_t              data_item,
    input  wire logic               kept_valid,
    input  wire logic               kept_stall,
    input  kept_item_t              kept_item,
    output int                      mismatch_count,
    output int                      waiting_count
);

    localparam int REPORT_LIMIT = 10;

    // Register copies as written over the register port.
    logic [LEN_W-1:0]  cfg_len;
    logic [DATA_W-1:0] cfg_word [NUM_WORDS];

    // Unresolved words, oldest at index 0.
    logic [DATA_W-1:0] window [NUM_WORDS];
    int                window_fill;
    int                len_in_force;

    // Kept words still owed by the block, oldest first.
    kept_item_t        kept_owed_q [$];

    // Resolve one data word against the window and queue the kept words it
    // releases.
    task automatic strip_pattern(input data_item_t req);
        kept_item_t released [$];
        kept_item_t one;
        bit         hit;
        if (window_fill == 0)
        begin
            if (cfg_len == 0)
                len_in_force = 1;
            else if (cfg_len > NUM_WORDS)
                len_in_force = NUM_WORDS;
            else
                len_in_force = cfg_len;
        end
        if (window_fill < NUM_WORDS)
        begin
            window[window_fill] = req.data_word;
            window_fill++;
        end
        if (window_fill >= len_in_force)
        begin
            hit = 1'b1;
            for (int i = 0; i < len_in_force; i++)
                if (window[i] != cfg_word[i])
                    hit = 1'b0;
            if (hit)
                window_fill = 0;
            else
            begin
                one = '{kept_word: window[0], final_out: 1'b0, marker_only: 1'b0};
                released = {released, one};
                for (int i = 1; i < window_fill; i++)
                    window[i-1] = window[i];
                window_fill--;
            end
        end
        // A final word flushes what is left, or sends a bare end marker.
        if (req.final_in)
        begin
            for (int i = 0; i < window_fill; i++)
            begin
                one = '{kept_word: window[i], final_out: 1'b0, marker_only: 1'b0};
                released = {released, one};
            end
            window_fill = 0;
            if (released.size() == 0)
            begin
                one = '{kept_word: '0, final_out: 1'b1, marker_only: 1'b1};
                released = {released, one};
            end
            else
                released[released.size()-1].final_out = 1'b1;
        end
        foreach (released[i])
            kept_owed_q = {kept_owed_q, released[i]};
    endtask

    // Compare one result request with the oldest kept word owed.
    task automatic check_kept(input kept_item_t got);
        kept_item_t want;
        if (kept_owed_q.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: unexpected result word=%h final=%b marker=%b",
                         $realtime, got.kept_word, got.final_out, got.marker_only);
            mismatch_count++;
        end
        else
        begin
            want = kept_owed_q.pop_front();
            if (got.kept_word !== want.kept_word || got.final_out !== want.final_out ||
                got.marker_only !== want.marker_only)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display({"%0t: result mismatch expected word=%h final=%b marker=%b,",
                              " got word=%h final=%b marker=%b"},
                             $realtime, want.kept_word, want.final_out, want.marker_only,
                             got.kept_word, got.final_out, got.marker_only);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len = 3'd1;
            foreach (cfg_word[i])
                cfg_word[i] = '0;
            foreach (window[i])
                window[i] = '0;
            window_fill = 0;
            len_in_force = 1;
            kept_owed_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            // A result taken now cannot come from a request taken at this edge.
            if (kept_valid && !kept_stall)
                check_kept(kept_item);

            // Register writes land at the access phase.
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_PATTERN_LEN)
                    cfg_len = pwdata[LEN_W-1:0];
                else if (paddr[PADDR_W-1:2] >= REG_PATTERN_WORD_0 &&
                         paddr[PADDR_W-1:2] <= REG_PATTERN_WORD_5)
                    cfg_word[paddr[PADDR_W-1:2] - REG_PATTERN_WORD_0] = pwdata[DATA_W-1:0];
            end

            if (data_valid && !data_stall)
                strip_pattern(data_item);
        end
        waiting_count = kept_owed_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import spr_pkg::*;

    // An address past the last register; writes there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int ITEM_TARGET = 290;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               data_valid = 1'b0;
    logic               data_stall;
    data_item_t         data_item = '0;
    logic               kept_valid;
    logic               kept_stall = 1'b0;
    kept_item_t         kept_item;

    int                 mismatch_count;
    int                 waiting_count;
    int                 items_sent = 0;
    bit                 calm = 1'b0;
    logic [DATA_W-1:0]  pat [NUM_WORDS];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stream_pattern_remover u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_item  (data_item),
        .kept_valid (kept_valid),
        .kept_stall (kept_stall),
        .kept_item  (kept_item)
    );

    spr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .data_valid     (data_valid),
        .data_stall     (data_stall),
        .data_item      (data_item),
        .kept_valid     (kept_valid),
        .kept_stall     (kept_stall),
        .kept_item      (kept_item),
        .mismatch_count (mismatch_count),
        .waiting_count  (waiting_count)
    );

    // The result side stalls at random, except during the calm stretch.
    always @(negedge clk)
        kept_stall <= !calm && ($urandom_range(99) < 35);

    // Register write: setup phase, then access phase until pready, then an
    // idle gap with psel low, so that back-to-back writes never touch psel twice at once.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Write the length and every pattern word from pat.
    task automatic load_pattern(input logic [PDATA_W-1:0] len_value);
        reg_write(REG_PATTERN_LEN, len_value);
        for (int i = 0; i < NUM_WORDS; i++)
            reg_write(REG_IDX_W'(REG_PATTERN_WORD_0 + i), pat[i]);
    endtask

    // Offer one data request, with random idle cycles ahead of it, and hold
    // it until the block takes it.
    task automatic send_request(input logic [DATA_W-1:0] w, input logic fin);
        while (!calm && $urandom_range(99) < 35)
        begin
            data_valid <= 1'b0;
            @(negedge clk);
        end
        data_valid <= 1'b1;
        data_item <= '{data_word: w, final_in: fin};
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending until every predicted result is out, then let a matched
    // word or a flush finish inside the block.
    task automatic settle();
        data_valid <= 1'b0;
        while (waiting_count != 0)
            @(negedge clk);
        repeat (12)
            @(negedge clk);
    endtask

    initial
    begin
        logic [PDATA_W-1:0] len_value;
        logic [DATA_W-1:0]  alpha [3];
        logic [DATA_W-1:0]  seq_q [$];
        int                 phase;
        int                 phase_end;
        int                 run_len;
        int                 seq_len;
        int                 cut;
        int                 pick;
        bit                 keep_open;

        foreach (pat[i])
            pat[i] = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset pattern is a single zero word; extremes pass untouched.
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h7fff_ffff, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hffff_ffff, 1'b1);
        // A sequence removed entirely yields only the end marker.
        send_request(32'h0000_0000, 1'b1);
        settle();

        // Overlapping candidates: only the leftmost occurrence goes.
        pat = '{32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
        load_pattern(32'd2);
        send_request(32'd1, 1'b0);
        send_request(32'd1, 1'b0);
        send_request(32'd1, 1'b1);
        settle();

        // A length of zero behaves as one.
        pat[0] = 32'd7;
        load_pattern(32'd0);
        send_request(32'd7, 1'b1);
        settle();

        // A length of seven behaves as six; bits above the field are ignored.
        pat = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                32'hffff_ffff, 32'h0000_0001, 32'h0000_0002};
        load_pattern(32'hffff_fff7);
        reg_write(REG_UNUSED, 32'h5a5a_a5a5);
        for (int i = 0; i < NUM_WORDS; i++)
            send_request(pat[i], 1'b0);
        send_request(32'd9, 1'b1);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h7fff_ffff, 1'b0);
        settle();

        // Mid-window: the new length waits for an empty window, while the
        // changed last word takes part in the very next compare.
        reg_write(REG_PATTERN_LEN, 32'd2);
        pat[5] = 32'd3;
        reg_write(REG_PATTERN_WORD_5, pat[5]);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hffff_ffff, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0003, 1'b1);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h7fff_ffff, 1'b1);
        settle();

        // Random phases: a new pattern over a small alphabet, then sequences
        // built mostly from whole and partial occurrences of it.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (phase == 4 || phase == 5);
            pick = $urandom_range(9);
            if (pick == 0)
                len_value = 32'd0;
            else if (pick == 1)
                len_value = 32'd7;
            else
                len_value = $urandom_range(1, NUM_WORDS);
            if ($urandom_range(3) == 0)
                len_value[PDATA_W-1:LEN_W] = (PDATA_W-LEN_W)'($urandom());
            if (len_value[LEN_W-1:0] == 0)
                run_len = 1;
            else if (len_value[LEN_W-1:0] > NUM_WORDS)
                run_len = NUM_WORDS;
            else
                run_len = int'(len_value[LEN_W-1:0]);

            foreach (alpha[k])
            begin
                pick = $urandom_range(5);
                if (pick == 0)
                    alpha[k] = 32'h8000_0000;
                else if (pick == 1)
                    alpha[k] = 32'h7fff_ffff;
                else
                    alpha[k] = $urandom();
            end
            reg_write(REG_PATTERN_LEN, len_value);
            for (int i = 0; i < NUM_WORDS; i++)
                if ($urandom_range(9) < 7)
                begin
                    pat[i] = alpha[$urandom_range(2)];
                    reg_write(REG_IDX_W'(REG_PATTERN_WORD_0 + i), pat[i]);
                end

            phase_end = items_sent + 25;
            while (items_sent < phase_end)
            begin
                seq_len = $urandom_range(1, 12);
                seq_q.delete();
                while (seq_q.size() < seq_len)
                begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                    begin
                        for (int i = 0; i < run_len; i++)
                            seq_q = {seq_q, pat[i]};
                    end
                    else if (pick < 60)
                    begin
                        cut = $urandom_range(0, run_len - 1);
                        for (int i = 0; i < cut; i++)
                            seq_q = {seq_q, pat[i]};
                    end
                    else if (pick < 90)
                        seq_q = {seq_q, alpha[$urandom_range(2)]};
                    else
                        seq_q = {seq_q, DATA_W'($urandom())};
                end
                // Most sequences close with a final word; some run on.
                keep_open = ($urandom_range(9) == 0);
                foreach (seq_q[i])
                    send_request(seq_q[i], !keep_open && (i == seq_q.size() - 1));
            end
            settle();
            phase++;
        end
        calm = 1'b0;

        settle();
        if (mismatch_count == 0)
            $display("PASS stream_pattern_remover");
        else
            $display("FAIL stream_pattern_remover");
        $finish;
    end

    // Hang guard.
    initial
    begin
        #2_000_000;
        $display("FAIL stream_pattern_remover");
        $finish;
    end

endmodule
